// File: src/constant_verification_cam_defines.svh
// Assertion macros shared by the constant verification CAM.
// Taken in by `include from the top level; depends on nothing else.
`ifndef CONSTANT_VERIFICATION_CAM_DEFINES_SVH
`define CONSTANT_VERIFICATION_CAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CVC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("constant verification CAM: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("constant verification CAM: next-cycle check failed");

`endif

// File: src/cvc_pkg.sv
// Shared types and constants of the constant verification CAM.
// Used by cvc_cell and constant_verification_cam; depends on nothing.
`default_nettype none

package cvc_pkg;

  localparam int THREAD_W   = 2;
  localparam int THREADS    = 1 << THREAD_W;
  localparam int ENTRIES    = 16;
  localparam int ADDR_W     = 48;
  localparam int INDEX_BITS = 10;
  localparam int CNT_W      = 5;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_CHECK  = 2'd1,
    OP_INSERT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic compact;
    logic shift;
    logic write;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/cvc_cell.sv
// One slot position of the table, holding that slot for every thread.
// Depends on cvc_pkg; chained by constant_verification_cam.
`default_nettype none

module cvc_cell (
  input  wire logic                             clk,
  input  wire logic [cvc_pkg::THREAD_W-1:0]     thread,
  input  wire cvc_pkg::cell_ctl_t               ctl,
  input  wire logic                             valid,
  input  wire logic [cvc_pkg::ADDR_W-1:0]       address,
  input  wire logic [cvc_pkg::INDEX_BITS-1:0]   lvpt_index,
  input  wire logic [cvc_pkg::ADDR_W-1:0]       up_addr,
  input  wire logic [cvc_pkg::INDEX_BITS-1:0]   up_idx,
  input  wire logic                             seen_in,
  output logic                                  seen_out,
  output logic                                  hit,
  output logic [cvc_pkg::ADDR_W-1:0]            out_addr,
  output logic [cvc_pkg::INDEX_BITS-1:0]        out_idx
);

  logic [cvc_pkg::ADDR_W-1:0]     addr_q [cvc_pkg::THREADS];
  logic [cvc_pkg::INDEX_BITS-1:0] idx_q  [cvc_pkg::THREADS];
  logic                           addr_eq;
  logic                           take_up;

  assign out_addr = addr_q[thread];
  assign out_idx  = idx_q[thread];
  assign addr_eq  = valid && (out_addr == address);
  assign hit      = addr_eq && (out_idx == lvpt_index);
  assign seen_out = seen_in || addr_eq;
  assign take_up  = ctl.shift || (ctl.compact && seen_out);

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      addr_q[thread] <= address;
      idx_q[thread]  <= lvpt_index;
    end else if (take_up) begin
      addr_q[thread] <= up_addr;
      idx_q[thread]  <= up_idx;
    end
  end

endmodule

`default_nettype wire

// File: src/constant_verification_cam.sv
// Top level of the constant verification CAM: control, occupancy and the cell chain.
// Depends on cvc_pkg, cvc_cell and constant_verification_cam_defines.svh.
//
// Usage: items enter on the s_ group, results leave on the m_ group, one result
// per item. The capacity register is written on the cfg_ channel; the user must
// write it only while idle, as the block itself does not enforce this. A load
// check compares all slots of the thread at once; its result, like that of an
// insert, appears in the output register in the cycle after acceptance. A store
// removes one matching entry per cycle by shifting the slots above it down one step
// along the cell chain; with no match left, its result enters the output register.
// One item is worked on at a time: s_tready is high only when no store is in
// progress and the output register is empty or being emptied in that cycle.
// When the receiver stalls, the result waits in the output register and no
// new item is taken. Reset empties every thread's table, clears the output
// valid and sets the capacity to 16; no clearing pass is needed.
`default_nettype none
`include "constant_verification_cam_defines.svh"

module constant_verification_cam (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [63:0] s_tdata,  // thread[1:0], address[49:2], lvpt_index[59:50], zeros
  input  wire logic [1:0] s_tuser,   // op[1:0]
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // hit[0], removed_count[5:1], evicted[6], zero
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data
);

  localparam int TH_LO  = 0;
  localparam int AD_LO  = TH_LO + cvc_pkg::THREAD_W;
  localparam int IX_LO  = AD_LO + cvc_pkg::ADDR_W;

  typedef enum logic {ST_IDLE, ST_STORE} state_t;

  state_t                         state;
  logic [cvc_pkg::THREAD_W-1:0]   st_thread;
  logic [cvc_pkg::ADDR_W-1:0]     st_addr;
  logic [cvc_pkg::CNT_W-1:0]      count;
  logic [cvc_pkg::CNT_W-1:0]      occ_q [cvc_pkg::THREADS];
  logic [cvc_pkg::CNT_W-1:0]      cap_q;

  logic                           s_accept;
  cvc_pkg::op_t                   op;
  logic [cvc_pkg::THREAD_W-1:0]   cur_thread;
  logic [cvc_pkg::ADDR_W-1:0]     cur_addr;
  logic [cvc_pkg::INDEX_BITS-1:0] in_idx;
  logic [cvc_pkg::CNT_W-1:0]      occ_cur;
  logic                           evict;
  logic [cvc_pkg::CNT_W-1:0]      wpos;
  logic                           do_insert;
  logic                           any_seen;
  logic                           any_hit;
  logic                           out_load;

  logic [cvc_pkg::ADDR_W-1:0]     c_addr [cvc_pkg::ENTRIES];
  logic [cvc_pkg::INDEX_BITS-1:0] c_idx  [cvc_pkg::ENTRIES];
  logic [cvc_pkg::ENTRIES-1:0]    c_seen;
  logic [cvc_pkg::ENTRIES-1:0]    c_hit;

  assign s_tready   = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_accept   = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;
  assign op         = cvc_pkg::op_t'(s_tuser);
  assign in_idx     = s_tdata[IX_LO +: cvc_pkg::INDEX_BITS];
  assign cur_thread = (state == ST_STORE) ? st_thread : s_tdata[TH_LO +: cvc_pkg::THREAD_W];
  assign cur_addr   = (state == ST_STORE) ? st_addr : s_tdata[AD_LO +: cvc_pkg::ADDR_W];
  assign occ_cur    = occ_q[cur_thread];
  assign evict      = (occ_cur >= cap_q);
  assign wpos       = evict ? (occ_cur - 1'b1) : occ_cur;
  assign do_insert  = s_accept && (op == cvc_pkg::OP_INSERT);
  assign any_seen   = c_seen[cvc_pkg::ENTRIES-1];
  assign any_hit    = |c_hit;
  assign out_load   = (s_accept && (op != cvc_pkg::OP_STORE)) ||
                      ((state == ST_STORE) && !any_seen);

  for (genvar i = 0; i < cvc_pkg::ENTRIES; i++) begin : g_cell
    cvc_pkg::cell_ctl_t             ctl;
    logic [cvc_pkg::ADDR_W-1:0]     up_addr;
    logic [cvc_pkg::INDEX_BITS-1:0] up_idx;
    logic                           seen_in;

    assign ctl.compact = (state == ST_STORE);
    assign ctl.shift   = do_insert && evict;
    assign ctl.write   = do_insert && (wpos == cvc_pkg::CNT_W'(i));

    if (i == cvc_pkg::ENTRIES - 1) begin : g_top
      assign up_addr = '0;
      assign up_idx  = '0;
    end else begin : g_mid
      assign up_addr = c_addr[i+1];
      assign up_idx  = c_idx[i+1];
    end

    if (i == 0) begin : g_first
      assign seen_in = 1'b0;
    end else begin : g_rest
      assign seen_in = c_seen[i-1];
    end

    cvc_cell u_cell (
      .clk        (clk),
      .thread     (cur_thread),
      .ctl        (ctl),
      .valid      (cvc_pkg::CNT_W'(i) < occ_cur),
      .address    (cur_addr),
      .lvpt_index (in_idx),
      .up_addr    (up_addr),
      .up_idx     (up_idx),
      .seen_in    (seen_in),
      .seen_out   (c_seen[i]),
      .hit        (c_hit[i]),
      .out_addr   (c_addr[i]),
      .out_idx    (c_idx[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      cap_q    <= cvc_pkg::CNT_W'(cvc_pkg::ENTRIES);
      for (int t = 0; t < cvc_pkg::THREADS; t++) begin
        occ_q[t] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_data == '0) begin
          cap_q <= cvc_pkg::CNT_W'(1);
        end else if (cfg_data > cvc_pkg::CNT_W'(cvc_pkg::ENTRIES)) begin
          cap_q <= cvc_pkg::CNT_W'(cvc_pkg::ENTRIES);
        end else begin
          cap_q <= cfg_data;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            case (op)
              cvc_pkg::OP_STORE: begin
                state     <= ST_STORE;
                st_thread <= cur_thread;
                st_addr   <= cur_addr;
                count     <= '0;
              end
              cvc_pkg::OP_CHECK: begin
                m_tdata  <= {2'b00, {cvc_pkg::CNT_W{1'b0}}, any_hit};
              end
              cvc_pkg::OP_INSERT: begin
                m_tdata  <= {1'b0, evict, {cvc_pkg::CNT_W{1'b0}}, 1'b0};
                if (!evict) begin
                  occ_q[cur_thread] <= occ_cur + 1'b1;
                end
              end
              default: begin
                m_tdata  <= '0;
              end
            endcase
          end
        end
        ST_STORE: begin
          if (any_seen) begin
            occ_q[cur_thread] <= occ_cur - 1'b1;
            count             <= count + 1'b1;
          end else begin
            state    <= ST_IDLE;
            m_tdata  <= {2'b00, count, (count != '0)};
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CVC_ASSERT_NEXT(a_store_done, clk, rst, (state == ST_STORE) && !any_seen, m_tvalid && (state == ST_IDLE))
  `CVC_ASSERT_IMPLY(a_no_evict_empty, clk, rst, do_insert && (occ_cur == '0), !evict)
  `CVC_ASSERT_IMPLY(a_busy_not_ready, clk, rst, state == ST_STORE, !s_tready && !m_tvalid)
  `CVC_ASSERT_IMPLY(a_occ_bound, clk, rst, 1'b1, occ_cur <= cvc_pkg::CNT_W'(cvc_pkg::ENTRIES))

endmodule

`default_nettype wire
